### src/fct_pkg.sv
package fct_pkg;

  // register file shape
  localparam int PlaneCount     = 6;
  localparam int SidePlaneCount = 4;
  localparam int PlaneW         = 64;
  localparam int CfgIdxW        = 3;

  // radius / half size: Q14.8 unsigned
  localparam int ExtW = 22;

  localparam int ReqTypeW = 3;

  typedef enum logic [ReqTypeW-1:0] {
    REQ_POINT     = 3'd0,
    REQ_SPHERE    = 3'd1,
    REQ_CUBE      = 3'd2,
    REQ_BOX       = 3'd3,
    REQ_BOX_SIDES = 3'd4
  } fct_req_e;

  // per-item control carried down the chain
  typedef struct packed {
    logic sel_corner;  // pick, per axis, the corner farthest along the plane normal
    logic use_ext;     // add radius term to the distance
    logic side_only;   // far and near planes do not apply
    logic force_pass;  // unknown request code, never culled
    logic pass;        // running verdict
  } fct_ctl_t;

endpackage

### src/fct_if.sv
interface fct_req_if #(
  parameter int COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic [fct_pkg::ReqTypeW-1:0]  req_type;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;
  logic signed [COORD_WIDTH-1:0] far_x;
  logic signed [COORD_WIDTH-1:0] far_y;
  logic signed [COORD_WIDTH-1:0] far_z;
  logic [fct_pkg::ExtW-1:0]      extent;

  modport source (
    output valid, req_type, pos_x, pos_y, pos_z, far_x, far_y, far_z, extent,
    input  ready
  );
  modport sink (
    input  valid, req_type, pos_x, pos_y, pos_z, far_x, far_y, far_z, extent,
    output ready
  );
endinterface

interface fct_res_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (
    output valid, inside_res,
    input  ready
  );
  modport sink (
    input  valid, inside_res,
    output ready
  );
endinterface

### src/fct_prep.sv
module fct_prep #(
  parameter int COORD_WIDTH = 24,
  parameter int CORNER_W    = 25
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              up_valid_i,
  output logic                              up_ready_o,
  input  logic [fct_pkg::ReqTypeW-1:0]      req_type_i,
  input  logic [2:0][COORD_WIDTH-1:0]       pos_i,
  input  logic [2:0][COORD_WIDTH-1:0]       far_i,
  input  logic [fct_pkg::ExtW-1:0]          ext_i,
  output logic                              dn_valid_o,
  input  logic                              dn_ready_i,
  output fct_pkg::fct_ctl_t                 dn_ctl_o,
  output logic [2:0][CORNER_W-1:0]          dn_lo_o,
  output logic [2:0][CORNER_W-1:0]          dn_hi_o,
  output logic [fct_pkg::ExtW-1:0]          dn_ext_o
);
  import fct_pkg::*;

  logic                     valid_q;
  logic                     en;
  fct_ctl_t                 ctl_d, ctl_q;
  logic [2:0][CORNER_W-1:0] lo_d, lo_q, hi_d, hi_q;
  logic [ExtW-1:0]          ext_q;
  logic [CORNER_W-1:0]      ext_e;
  logic [CORNER_W-1:0]      pos_e [3];
  logic [CORNER_W-1:0]      far_e [3];

  assign en         = !valid_q || dn_ready_i;
  assign up_ready_o = en;
  assign ext_e      = CORNER_W'(ext_i);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pos_e[k] = CORNER_W'($signed(pos_i[k]));
      far_e[k] = CORNER_W'($signed(far_i[k]));
    end
    ctl_d = '{sel_corner: 1'b0, use_ext: 1'b0, side_only: 1'b0,
              force_pass: 1'b0, pass: 1'b1};
    for (int k = 0; k < 3; k++) begin
      lo_d[k] = pos_e[k];
      hi_d[k] = pos_e[k];
    end
    case (req_type_i)
      REQ_POINT: begin
      end
      REQ_SPHERE: begin
        ctl_d.use_ext = 1'b1;
      end
      REQ_CUBE: begin
        ctl_d.sel_corner = 1'b1;
        for (int k = 0; k < 3; k++) begin
          lo_d[k] = pos_e[k] - ext_e;
          hi_d[k] = pos_e[k] + ext_e;
        end
      end
      REQ_BOX: begin
        ctl_d.sel_corner = 1'b1;
        for (int k = 0; k < 3; k++) hi_d[k] = far_e[k];
      end
      REQ_BOX_SIDES: begin
        ctl_d.sel_corner = 1'b1;
        ctl_d.side_only  = 1'b1;
        for (int k = 0; k < 3; k++) hi_d[k] = far_e[k];
      end
      default: begin
        ctl_d.force_pass = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && up_valid_i) begin
      ctl_q <= ctl_d;
      lo_q  <= lo_d;
      hi_q  <= hi_d;
      ext_q <= ext_i;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_ctl_o   = ctl_q;
  assign dn_lo_o    = lo_q;
  assign dn_hi_o    = hi_q;
  assign dn_ext_o   = ext_q;

endmodule

### src/fct_cell.sv
module fct_cell #(
  parameter int NW       = 14,
  parameter int CORNER_W = 25,
  parameter bit SIDE     = 1'b1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fct_pkg::PlaneW-1:0]        cfg_data_i,
  input  logic                              up_valid_i,
  output logic                              up_ready_o,
  input  fct_pkg::fct_ctl_t                 up_ctl_i,
  input  logic [2:0][CORNER_W-1:0]          up_lo_i,
  input  logic [2:0][CORNER_W-1:0]          up_hi_i,
  input  logic [fct_pkg::ExtW-1:0]          up_ext_i,
  output logic                              dn_valid_o,
  input  logic                              dn_ready_i,
  output fct_pkg::fct_ctl_t                 dn_ctl_o,
  output logic [2:0][CORNER_W-1:0]          dn_lo_o,
  output logic [2:0][CORNER_W-1:0]          dn_hi_o,
  output logic [fct_pkg::ExtW-1:0]          dn_ext_o
);
  import fct_pkg::*;

  localparam int DW     = PlaneW - 3 * NW;
  localparam int Frac   = NW - 2;
  localparam int ProdW  = NW + CORNER_W;
  localparam int T1     = ProdW + 2;
  localparam int T2     = DW + Frac;
  localparam int T3     = ExtW + Frac + 1;
  localparam int T12    = (T1 > T2) ? T1 : T2;
  localparam int DistW  = ((T12 > T3) ? T12 : T3) + 2;

  logic [PlaneW-1:0] plane_q;

  // stage 1: corner pick and products
  logic                     s1_valid_q, s1_en;
  fct_ctl_t                 s1_ctl_q;
  logic [2:0][CORNER_W-1:0] s1_lo_q, s1_hi_q;
  logic [ExtW-1:0]          s1_ext_q;
  logic signed [ProdW-1:0]  s1_prod_d [3];
  logic signed [ProdW-1:0]  s1_prod_q [3];
  logic signed [DistW-1:0]  s1_off_d, s1_off_q;

  // stage 2: sum and compare
  logic                     s2_valid_q, s2_en;
  fct_ctl_t                 s2_ctl_d, s2_ctl_q;
  logic [2:0][CORNER_W-1:0] s2_lo_q, s2_hi_q;
  logic [ExtW-1:0]          s2_ext_q;
  logic signed [DistW-1:0]  dist_sum;

  logic signed [NW-1:0]       coef [3];
  logic signed [DW-1:0]       d_s;
  logic signed [CORNER_W-1:0] pick [3];
  logic                       hi_ge;

  assign s2_en      = !s2_valid_q || dn_ready_i;
  assign s1_en      = !s1_valid_q || s2_en;
  assign up_ready_o = s1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= '0;
    end else if (cfg_we_i) begin
      plane_q <= cfg_data_i;
    end
  end

  always_comb begin
    coef[0] = plane_q[NW-1:0];
    coef[1] = plane_q[2*NW-1:NW];
    coef[2] = plane_q[3*NW-1:2*NW];
    d_s     = plane_q[PlaneW-1:3*NW];
    for (int k = 0; k < 3; k++) begin
      hi_ge   = $signed(up_hi_i[k]) >= $signed(up_lo_i[k]);
      // the corner farthest along the normal; lo holds the point otherwise
      if (up_ctl_i.sel_corner && (!coef[k][NW-1] == hi_ge)) begin
        pick[k] = up_hi_i[k];
      end else begin
        pick[k] = up_lo_i[k];
      end
      s1_prod_d[k] = pick[k] * coef[k];
    end
    s1_off_d = (DistW'(d_s) <<< Frac)
             + (up_ctl_i.use_ext ? (DistW'(up_ext_i) << Frac) : DistW'(0));
  end

  always_comb begin
    dist_sum = DistW'(s1_prod_q[0]) + DistW'(s1_prod_q[1]) + DistW'(s1_prod_q[2])
             + s1_off_q;
    s2_ctl_d = s1_ctl_q;
    if (!s1_ctl_q.force_pass && !(SIDE == 1'b0 && s1_ctl_q.side_only)) begin
      if (dist_sum[DistW-1] || dist_sum == '0) s2_ctl_d.pass = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_en) s1_valid_q <= up_valid_i;
      if (s2_en) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && up_valid_i) begin
      s1_ctl_q  <= up_ctl_i;
      s1_lo_q   <= up_lo_i;
      s1_hi_q   <= up_hi_i;
      s1_ext_q  <= up_ext_i;
      s1_prod_q <= s1_prod_d;
      s1_off_q  <= s1_off_d;
    end
    if (s2_en && s1_valid_q) begin
      s2_ctl_q <= s2_ctl_d;
      s2_lo_q  <= s1_lo_q;
      s2_hi_q  <= s1_hi_q;
      s2_ext_q <= s1_ext_q;
    end
  end

  assign dn_valid_o = s2_valid_q;
  assign dn_ctl_o   = s2_ctl_q;
  assign dn_lo_o    = s2_lo_q;
  assign dn_hi_o    = s2_hi_q;
  assign dn_ext_o   = s2_ext_q;

endmodule

### src/frustum_cull_test.sv
// channel  | dir | handshake     | word
// ---------+-----+---------------+-------------------------------------------
// req      | in  | valid / ready | req_type, pos_x/y/z, far_x/y/z, extent
// res      | out | valid / ready | inside_res
// cfg      | in  | cfg_we_i      | cfg_idx_i, cfg_data_i (64-bit plane word)
//
// one word per cycle while res is ready; one input stage, then two
// stages in each of the six plane cells (products, then sum and compare)
// rst_ni clears every valid bit and all six planes to zero
// a stalled res holds only the stages behind it that are full; bubbles close
// up, so req keeps being taken while a result waits
module frustum_cull_test #(
  parameter int COORD_WIDTH  = 24,
  parameter int NORMAL_WIDTH = 14
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  fct_req_if.sink                         req,
  fct_res_if.source                       res,
  input  logic                            cfg_we_i,
  input  logic [fct_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [fct_pkg::PlaneW-1:0]      cfg_data_i
);
  import fct_pkg::*;

  // corners of a cube reach past the coordinate range by the half size
  localparam int CornerW = ((COORD_WIDTH > ExtW) ? COORD_WIDTH : ExtW + 1) + 1;

  // chain links: index 0 is the input stage, index p+1 is plane cell p
  logic                    ch_valid [PlaneCount+1];
  logic                    ch_ready [PlaneCount+1];
  fct_ctl_t                ch_ctl   [PlaneCount+1];
  logic [2:0][CornerW-1:0] ch_lo    [PlaneCount+1];
  logic [2:0][CornerW-1:0] ch_hi    [PlaneCount+1];
  logic [ExtW-1:0]         ch_ext   [PlaneCount+1];

  logic [2:0][COORD_WIDTH-1:0] pos, far;

  assign pos = {req.pos_z, req.pos_y, req.pos_x};
  assign far = {req.far_z, req.far_y, req.far_x};

  // input stage: decode the request, form the cube corners
  fct_prep #(
    .COORD_WIDTH (COORD_WIDTH),
    .CORNER_W    (CornerW)
  ) u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (req.valid),
    .up_ready_o (req.ready),
    .req_type_i (req.req_type),
    .pos_i      (pos),
    .far_i      (far),
    .ext_i      (req.extent),
    .dn_valid_o (ch_valid[0]),
    .dn_ready_i (ch_ready[0]),
    .dn_ctl_o   (ch_ctl[0]),
    .dn_lo_o    (ch_lo[0]),
    .dn_hi_o    (ch_hi[0]),
    .dn_ext_o   (ch_ext[0])
  );

  // one cell per plane, in register order: right, left, bottom, top, back, front;
  // each cell owns its plane register
  for (genvar p = 0; p < PlaneCount; p++) begin : g_cell
    logic we;
    assign we = cfg_we_i && (cfg_idx_i == CfgIdxW'(p));

    fct_cell #(
      .NW       (NORMAL_WIDTH),
      .CORNER_W (CornerW),
      .SIDE     (p < SidePlaneCount)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cfg_we_i   (we),
      .cfg_data_i (cfg_data_i),
      .up_valid_i (ch_valid[p]),
      .up_ready_o (ch_ready[p]),
      .up_ctl_i   (ch_ctl[p]),
      .up_lo_i    (ch_lo[p]),
      .up_hi_i    (ch_hi[p]),
      .up_ext_i   (ch_ext[p]),
      .dn_valid_o (ch_valid[p+1]),
      .dn_ready_i (ch_ready[p+1]),
      .dn_ctl_o   (ch_ctl[p+1]),
      .dn_lo_o    (ch_lo[p+1]),
      .dn_hi_o    (ch_hi[p+1]),
      .dn_ext_o   (ch_ext[p+1])
    );
  end

  // last cell's output stage is the result register
  assign res.valid            = ch_valid[PlaneCount];
  assign res.inside_res       = ch_ctl[PlaneCount].pass;
  assign ch_ready[PlaneCount] = res.ready;

endmodule
